>>> sv/tfr_pkg.sv
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types and constants for the typed frame receiver with CRC-16.
// ----------------------------------------------------------------------------
package tfr_pkg;

    // Payload capacity in bytes; widths of the payload counters follow from it
    localparam int MAX_PAYLOAD = 64;
    localparam int POS_W       = $clog2(MAX_PAYLOAD + 1);

    // Legal length word range: L >= 2, and L - 2 may not exceed the capacity
    localparam logic [15:0] LEN_MIN = 16'd2;
    localparam logic [15:0] LEN_MAX = 16'(MAX_PAYLOAD + 2);

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_WORD   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_SENSOR  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_DEVICE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_CONTROL = 4'd3;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // Frame types
    localparam logic [1:0] FT_SENSOR  = 2'd0;
    localparam logic [1:0] FT_DEVICE  = 2'd1;
    localparam logic [1:0] FT_CONTROL = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_START = 3'd1;
    localparam logic [2:0] ERR_TYPE  = 3'd2;
    localparam logic [2:0] ERR_LEN   = 3'd3;
    localparam logic [2:0] ERR_CRC   = 3'd4;

    localparam int TDATA_W = 32;

    typedef struct packed {
        logic [15:0] start_word;
        logic [15:0] type_sensor;
        logic [15:0] type_device;
        logic [15:0] type_control;
    } cfg_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] payload_byte;
        logic [5:0] payload_index;
        logic [1:0] frame_type;
        logic [2:0] error_code;
        logic [6:0] frame_bytes;
    } result_t;

endpackage

>>> sv/tfr_crc16.sv
// ----------------------------------------------------------------------------
// tfr_crc16
// One-byte CRC-16/MODBUS update, reflected, LSB first.
// ----------------------------------------------------------------------------
module tfr_crc16 (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import tfr_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        crc_out = c;
    end

endmodule

>>> sv/tfr_parser.sv
// ----------------------------------------------------------------------------
// tfr_parser
// Frame state machine: header decode, payload emission, CRC check.
// ----------------------------------------------------------------------------
module tfr_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  tfr_pkg::cfg_t    cfg,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    input  logic             frame_first,
    output logic             res_valid,
    output tfr_pkg::result_t res
);
    import tfr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_CRC
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         held_reg, held_next;
    logic               toggle_reg, toggle_next;
    logic [1:0]         kind_reg, kind_next;
    logic [POS_W-1:0]   rem_reg, rem_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         crc_low_reg, crc_low_next;

    phase_t             eff_phase;
    logic               eff_toggle;
    logic [1:0]         eff_kind;
    logic [POS_W-1:0]   eff_pos;
    logic [POS_W-1:0]   eff_rem;
    logic [7:0]         eff_crc_low;
    logic [15:0]        crc_in;
    logic [15:0]        crc_upd;
    logic [15:0]        word;
    logic [15:0]        rx_crc;
    logic [15:0]        nb_sum;
    logic [15:0]        pos_wide;

    // A first-flagged byte restarts the frame before it is decoded
    assign eff_phase   = frame_first ? PH_START : phase_reg;
    assign eff_toggle  = frame_first ? 1'b0 : toggle_reg;
    assign eff_kind    = frame_first ? FT_SENSOR : kind_reg;
    assign eff_pos     = frame_first ? '0 : pos_reg;
    assign eff_rem     = frame_first ? '0 : rem_reg;
    assign eff_crc_low = frame_first ? 8'h00 : crc_low_reg;
    assign crc_in      = frame_first ? CRC_INIT : crc_reg;

    assign word     = {rx_byte, held_reg};
    assign rx_crc   = {rx_byte, eff_crc_low};
    assign pos_wide = 16'(eff_pos);
    assign nb_sum   = pos_wide + 16'd8;

    tfr_crc16 u_crc (
        .crc_in  (crc_in),
        .data    (rx_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        held_next    = held_reg;
        toggle_next  = toggle_reg;
        kind_next    = kind_reg;
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        crc_low_next = crc_low_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (accept && (frame_first || phase_reg != PH_IDLE))
        begin
            phase_next   = eff_phase;
            toggle_next  = eff_toggle;
            kind_next    = eff_kind;
            rem_next     = eff_rem;
            pos_next     = eff_pos;
            crc_low_next = eff_crc_low;
            if (eff_phase != PH_CRC)
                crc_next = crc_upd;
            else
                crc_next = crc_in;

            unique case (eff_phase)
                PH_START, PH_TYPE, PH_LEN:
                begin
                    if (!eff_toggle)
                    begin
                        held_next   = rx_byte;
                        toggle_next = 1'b1;
                    end
                    else
                    begin
                        toggle_next = 1'b0;
                        if (eff_phase == PH_START)
                        begin
                            if (word != cfg.start_word)
                            begin
                                phase_next     = PH_IDLE;
                                res_valid      = 1'b1;
                                res.out_kind   = KIND_REJECT;
                                res.error_code = ERR_START;
                            end
                            else
                                phase_next = PH_TYPE;
                        end
                        else if (eff_phase == PH_TYPE)
                        begin
                            // sensor wins over device, device over control
                            phase_next = PH_LEN;
                            if (word == cfg.type_sensor)
                                kind_next = FT_SENSOR;
                            else if (word == cfg.type_device)
                                kind_next = FT_DEVICE;
                            else if (word == cfg.type_control)
                                kind_next = FT_CONTROL;
                            else
                            begin
                                phase_next     = PH_IDLE;
                                res_valid      = 1'b1;
                                res.out_kind   = KIND_REJECT;
                                res.error_code = ERR_TYPE;
                            end
                        end
                        else
                        begin
                            if (word < LEN_MIN || word > LEN_MAX)
                            begin
                                phase_next     = PH_IDLE;
                                res_valid      = 1'b1;
                                res.out_kind   = KIND_REJECT;
                                res.frame_type = eff_kind;
                                res.error_code = ERR_LEN;
                            end
                            else
                            begin
                                rem_next   = POS_W'(word - LEN_MIN);
                                pos_next   = '0;
                                phase_next = (word == LEN_MIN) ? PH_CRC : PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid         = 1'b1;
                    res.out_kind      = KIND_PAYLOAD;
                    res.payload_index = pos_wide[5:0];
                    res.frame_type    = eff_kind;
                    // control frames hide payload past the first two bytes
                    if (eff_kind == FT_CONTROL && pos_wide >= 16'd2)
                        res.payload_byte = 8'h00;
                    else
                        res.payload_byte = rx_byte;
                    pos_next = eff_pos + POS_W'(1);
                    rem_next = eff_rem - POS_W'(1);
                    if (eff_rem == POS_W'(1))
                        phase_next = PH_CRC;
                end
                PH_CRC:
                begin
                    if (!eff_toggle)
                    begin
                        crc_low_next = rx_byte;
                        toggle_next  = 1'b1;
                    end
                    else
                    begin
                        toggle_next    = 1'b0;
                        phase_next     = PH_IDLE;
                        res_valid      = 1'b1;
                        res.frame_type = eff_kind;
                        if (rx_crc != crc_in)
                        begin
                            res.out_kind   = KIND_REJECT;
                            res.error_code = ERR_CRC;
                        end
                        else
                        begin
                            res.out_kind    = KIND_ACCEPT;
                            res.frame_bytes = nb_sum[6:0];
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            crc_reg     <= CRC_INIT;
            held_reg    <= 8'h00;
            toggle_reg  <= 1'b0;
            kind_reg    <= FT_SENSOR;
            rem_reg     <= '0;
            pos_reg     <= '0;
            crc_low_reg <= 8'h00;
        end
        else
        begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            held_reg    <= held_next;
            toggle_reg  <= toggle_next;
            kind_reg    <= kind_next;
            rem_reg     <= rem_next;
            pos_reg     <= pos_next;
            crc_low_reg <= crc_low_next;
        end
    end

endmodule

>>> sv/tfr_out_buf.sv
// ----------------------------------------------------------------------------
// tfr_out_buf
// Output register with skid slot; input ready depends on registers only.
// ----------------------------------------------------------------------------
module tfr_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tfr_pkg::result_t push_data,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output tfr_pkg::result_t out_data
);
    import tfr_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pop       = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> sv/typed_frame_receiver_crc16_core.sv
// ----------------------------------------------------------------------------
// typed_frame_receiver_crc16_core
// Typed serial frame receiver: start/type/length header, payload, CRC-16.
// ----------------------------------------------------------------------------
// Results are registered in the output register or the skid slot.
// Throughput: one byte per cycle while the skid slot is free (s_tready low
// otherwise); the byte-wide CRC update and the header decode are combinational in front of the parser state registers.
// Reset (rst_n low, asynchronous): parser idle, CRC 0xFFFF, configuration
// registers zero, output buffer empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module typed_frame_receiver_crc16_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // byte stream in
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    input  logic                         s_tuser,   // [0] frame_first
    // result stream out
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] payload_byte, [13:8] payload_index, [15:14] frame_type,
    // [18:16] error_code, [25:19] frame_bytes, [31:26] zero
    output logic [tfr_pkg::TDATA_W-1:0]  m_tdata,
    output logic [1:0]                   m_tuser,   // [1:0] out_kind
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                  cfg_data
);
    import tfr_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    // Configuration is a plain register file; writes always complete.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_WORD:   cfg_next.start_word   = cfg_data;
                CFG_TYPE_SENSOR:  cfg_next.type_sensor  = cfg_data;
                CFG_TYPE_DEVICE:  cfg_next.type_device  = cfg_data;
                CFG_TYPE_CONTROL: cfg_next.type_control = cfg_data;
                default:          cfg_next = cfg_reg;    // unmapped index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // A byte transaction happens whenever a byte is offered and the skid slot is free, so bytes keep
    // flowing while one result waits at the output.
    assign accept = s_tvalid && s_tready;

    tfr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .rx_byte     (s_tdata),
        .frame_first (s_tuser),
        .res_valid   (res_valid),
        .res         (res)
    );

    // res_valid is only raised for an accepted byte
    tfr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.out_kind;
    assign m_tdata = {6'b000000,
                      out_res.frame_bytes,
                      out_res.error_code,
                      out_res.frame_type,
                      out_res.payload_index,
                      out_res.payload_byte};

endmodule
